// ===== hw/rtl/bug0_pkg.sv =====
package bug0_pkg;

	localparam int PosW    = 16;
	localparam int HdgW    = 15;
	localparam int RngW    = 10;
	localparam int CmdW    = 16;
	localparam int DeltaW  = 17;
	localparam int MulW    = 18;
	localparam int ProdW   = 2 * MulW;
	localparam int ErrW    = 18;
	localparam int CordXW  = 28;
	localparam int CordZW  = 20;
	localparam int CordN   = 16;
	localparam int CordCntW = $clog2(CordN);

	localparam logic signed [ErrW-1:0] Q12Pi    = 18'sd12868;
	localparam logic signed [ErrW-1:0] Q12TwoPi = 18'sd25736;
	localparam logic [ErrW-1:0]        Q12Pi16  = 18'd804;
	localparam logic signed [MulW-1:0] TurnGain = 18'sd819;
	localparam logic signed [MulW-1:0] CruiseFrac = 18'sd3277;
	localparam logic signed [ProdW-1:0] NearGoal2 = 36'sd262144;
	localparam logic signed [ProdW-1:0] WakeDist2 = 36'sd10404;
	localparam logic [RngW-1:0]        BackoffRange = 10'd205;
	localparam logic signed [MulW-1:0] SonarFull  = 18'sd512;
	localparam logic signed [MulW-1:0] SonarFifth = 18'sd102;
	localparam logic signed [CordZW-1:0] ZPi = 20'sd205887;

	typedef enum logic [1:0] {
		MODE_IDLE    = 2'd0,
		MODE_PURSUIT = 2'd1,
		MODE_WALL    = 2'd2
	} nav_mode_t;

	typedef enum logic [2:0] {
		REG_GOAL_X    = 3'd0,
		REG_GOAL_Y    = 3'd1,
		REG_LIN_MAX   = 3'd2,
		REG_LIN_MIN   = 3'd3,
		REG_ANG_MAX   = 3'd4,
		REG_ANG_MIN   = 3'd5,
		REG_GOAL_TOL  = 3'd6,
		REG_OBST_TRIG = 3'd7
	} reg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SQX,
		ST_SQY,
		ST_TOL,
		ST_DISP,
		ST_CORD,
		ST_WRAP,
		ST_RATE,
		ST_SON,
		ST_PFIN,
		ST_W1,
		ST_W2,
		ST_W3,
		ST_W4,
		ST_DONE
	} seq_state_t;

	function automatic logic signed [CordZW-1:0] cord_atan(input logic [CordCntW-1:0] i);
		logic signed [CordZW-1:0] r;
		begin
			case (i)
				4'd0:  r = 20'sd51472;
				4'd1:  r = 20'sd30385;
				4'd2:  r = 20'sd16055;
				4'd3:  r = 20'sd8150;
				4'd4:  r = 20'sd4091;
				4'd5:  r = 20'sd2047;
				4'd6:  r = 20'sd1024;
				4'd7:  r = 20'sd512;
				4'd8:  r = 20'sd256;
				4'd9:  r = 20'sd128;
				4'd10: r = 20'sd64;
				4'd11: r = 20'sd32;
				4'd12: r = 20'sd16;
				4'd13: r = 20'sd8;
				4'd14: r = 20'sd4;
				default: r = 20'sd2;
			endcase
			return r;
		end
	endfunction

	function automatic logic signed [CmdW-1:0] sat16(input logic signed [ProdW-1:0] v);
		logic signed [CmdW-1:0] r;
		begin
			if (v > 36'sd32767)
				r = 16'sh7fff;
			else if (v < -36'sd32768)
				r = 16'sh8000;
			else
				r = v[CmdW-1:0];
			return r;
		end
	endfunction

endpackage

// ===== hw/rtl/bug0_cordic.sv =====
module bug0_cordic import bug0_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic signed [DeltaW-1:0] dx,
	input  logic signed [DeltaW-1:0] dy,
	output logic                     done,
	output logic signed [CmdW-1:0]   bearing
);

	logic                     busy_q;
	logic                     done_q;
	logic                     zero_q;
	logic [CordCntW-1:0]      cnt_q;
	logic signed [CordXW-1:0] x_q, y_q;
	logic signed [CordZW-1:0] z_q;
	logic signed [CordXW-1:0] x0, y0;
	logic signed [CordZW-1:0] zr;

	assign x0 = {{(CordXW-DeltaW-8){dx[DeltaW-1]}}, dx, 8'd0};
	assign y0 = {{(CordXW-DeltaW-8){dy[DeltaW-1]}}, dy, 8'd0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CordCntW'(CordN - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// prerotate left half plane by pi, then one vectoring step a cycle
	always_ff @(posedge clk) begin
		if (start) begin
			zero_q <= (dx == '0) && (dy == '0);
			if (dx < 0) begin
				z_q <= (dy >= 0) ? ZPi : -ZPi;
				x_q <= -x0;
				y_q <= -y0;
			end else begin
				z_q <= '0;
				x_q <= x0;
				y_q <= y0;
			end
		end else if (busy_q) begin
			if (y_q >= 0) begin
				x_q <= x_q + (y_q >>> cnt_q);
				y_q <= y_q - (x_q >>> cnt_q);
				z_q <= z_q + cord_atan(cnt_q);
			end else begin
				x_q <= x_q - (y_q >>> cnt_q);
				y_q <= y_q + (x_q >>> cnt_q);
				z_q <= z_q - cord_atan(cnt_q);
			end
		end
	end

	assign zr      = (z_q + 20'sd8) >>> 4;
	assign done    = done_q;
	assign bearing = zero_q ? '0 : zr[CmdW-1:0];

endmodule

// ===== hw/rtl/bug0_navigation_controller.sv =====
// Channel  Dir  Fields (low bit first)
// s_*      in   pos_x[15:0] pos_y[31:16] heading[46:32] range_front[56:47]
//                range_left[66:57] range_right[76:67]
// m_*      out  lin_cmd[15:0] ang_cmd[31:16] nav_mode[33:32]
// cfg_*    in   write enable, register index, data
//
// Goal pursuit waits on the CORDIC (16 steps plus done) and the heading wrap;
// every mode runs its product steps on a shared 18x18 multiplier.
// A new item is taken only in the idle state; a finished result waits in the
// output register, so the next item is taken while it is pending. The done
// state holds while that register is full and m_tready is low.
// Reset (arst_n low) clears mode and held commands and loads register defaults.
module bug0_navigation_controller import bug0_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [79:0] s_tdata,   // pos_x, pos_y, heading, range_front, range_left, range_right
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // lin_cmd, ang_cmd, nav_mode
	input  logic        cfg_we,
	input  logic [2:0]  cfg_addr,
	input  logic [15:0] cfg_wdata
);

	seq_state_t state_q, state_d;

	logic signed [PosW-1:0] goal_x_q, goal_y_q;
	logic [14:0] lmax_q, lmin_q, amax_q, amin_q, tol_q, trig_q;

	logic signed [HdgW-1:0]   hdg_q;
	logic [RngW-1:0]          rf_q, rl_q, rr_q;
	logic signed [DeltaW-1:0] dx_q, dy_q;
	logic signed [ProdW-1:0]  prod_q, d2_q, tol2_q;
	logic signed [ErrW-1:0]   err_q;
	logic signed [CmdW-1:0]   ang_q, wang_q, wlin_q;
	logic signed [CmdW-1:0]   held_lin_q, held_ang_q;
	nav_mode_t                mode_q;

	logic                   m_valid_q;
	logic signed [CmdW-1:0] out_lin_q, out_ang_q;
	logic [1:0]             out_mode_q;

	logic signed [MulW-1:0]  mul_a, mul_b;
	logic                    cord_start, cord_done;
	logic signed [CmdW-1:0]  bearing;
	logic                    accept, out_free;
	logic [ErrW-1:0]         mag;
	logic signed [ProdW-1:0] rate;
	logic signed [ProdW-1:0] sonar_ang;
	logic signed [ProdW-1:0] p_lin;
	logic signed [ProdW-1:0] p_ang;

	assign accept   = s_tvalid && s_tready;
	assign s_tready = (state_q == ST_IDLE);
	assign out_free = !m_valid_q || m_tready;
	assign mag      = err_q[ErrW-1] ? 18'(-err_q) : 18'(err_q);

	bug0_cordic u_cordic (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cord_start),
		.dx      (dx_q),
		.dy      (dy_q),
		.done    (cord_done),
		.bearing (bearing)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			goal_x_q <= '0;
			goal_y_q <= '0;
			lmax_q   <= 15'd1638;
			lmin_q   <= 15'd819;
			amax_q   <= 15'd2458;
			amin_q   <= 15'd1638;
			tol_q    <= 15'd102;
			trig_q   <= 15'd512;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_addr))
				REG_GOAL_X:    goal_x_q <= cfg_wdata;
				REG_GOAL_Y:    goal_y_q <= cfg_wdata;
				REG_LIN_MAX:   lmax_q   <= cfg_wdata[14:0];
				REG_LIN_MIN:   lmin_q   <= cfg_wdata[14:0];
				REG_ANG_MAX:   amax_q   <= cfg_wdata[14:0];
				REG_ANG_MIN:   amin_q   <= cfg_wdata[14:0];
				REG_GOAL_TOL:  tol_q    <= cfg_wdata[14:0];
				REG_OBST_TRIG: trig_q   <= cfg_wdata[14:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d    = state_q;
		mul_a      = '0;
		mul_b      = '0;
		cord_start = 1'b0;
		unique case (state_q)
			ST_IDLE: if (accept) state_d = ST_SQX;
			ST_SQX: begin
				mul_a   = 18'(dx_q);
				mul_b   = 18'(dx_q);
				state_d = ST_SQY;
			end
			ST_SQY: begin
				mul_a   = 18'(dy_q);
				mul_b   = 18'(dy_q);
				state_d = ST_TOL;
			end
			ST_TOL: begin
				mul_a   = {3'd0, tol_q};
				mul_b   = {3'd0, tol_q};
				state_d = ST_DISP;
			end
			ST_DISP: begin
				if (mode_q == MODE_PURSUIT) begin
					cord_start = 1'b1;
					state_d    = ST_CORD;
				end else if (mode_q == MODE_WALL)
					state_d = ST_W1;
				else
					state_d = ST_DONE;
			end
			ST_CORD: if (cord_done) state_d = ST_WRAP;
			ST_WRAP: if (err_q <= Q12Pi && err_q > -Q12Pi) state_d = ST_RATE;
			ST_RATE: begin
				mul_a   = mag;
				mul_b   = TurnGain;
				state_d = ST_SON;
			end
			ST_SON: begin
				mul_a   = 18'($signed({1'b0, rr_q})) - 18'($signed({1'b0, rl_q}));
				mul_b   = {3'd0, amax_q};
				state_d = ST_PFIN;
			end
			ST_PFIN: state_d = ST_DONE;
			ST_W1: begin
				mul_a   = {3'd0, amax_q};
				mul_b   = SonarFull - 18'($signed({1'b0, rf_q}));
				state_d = ST_W2;
			end
			ST_W2: begin
				mul_a   = 18'($signed({1'b0, rf_q})) - SonarFifth;
				mul_b   = {3'd0, lmax_q};
				state_d = ST_W3;
			end
			ST_W3: begin
				mul_a   = {3'd0, lmax_q};
				mul_b   = CruiseFrac;
				state_d = ST_W4;
			end
			ST_W4: state_d = ST_DONE;
			ST_DONE: if (out_free) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// clamp the proportional turn rate; the minimum wins when limits cross
	always_comb begin
		rate = (prod_q + 36'sd2048) >>> 12;
		if (rate > $signed({21'd0, amax_q}))
			rate = {21'd0, amax_q};
		if (rate < $signed({21'd0, amin_q}))
			rate = {21'd0, amin_q};
	end

	assign sonar_ang = (prod_q + 36'sd512) >>> 10;
	assign p_ang     = (prod_q + 36'sd256) >>> 9;
	assign p_lin     = (prod_q + 36'sd512) >>> 10;

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					hdg_q <= s_tdata[46:32];
					rf_q  <= s_tdata[56:47];
					rl_q  <= s_tdata[66:57];
					rr_q  <= s_tdata[76:67];
					dx_q  <= 17'(goal_x_q) - 17'($signed(s_tdata[15:0]));
					dy_q  <= 17'(goal_y_q) - 17'($signed(s_tdata[31:16]));
				end
			end
			ST_SQY:  d2_q   <= prod_q;
			ST_TOL:  d2_q   <= d2_q + prod_q;
			ST_DISP: tol2_q <= prod_q;
			ST_CORD: err_q  <= 18'(bearing) - 18'(hdg_q);
			ST_WRAP: begin
				if (err_q > Q12Pi)
					err_q <= err_q - Q12TwoPi;
				else if (err_q <= -Q12Pi)
					err_q <= err_q + Q12TwoPi;
			end
			ST_SON: ang_q <= err_q[ErrW-1] ? 16'(-rate) : 16'(rate);
			ST_W2:  wang_q <= sat16(p_ang);
			ST_W3:  wlin_q <= sat16(p_lin);
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= MODE_IDLE;
			held_lin_q <= '0;
			held_ang_q <= '0;
		end else begin
			unique case (state_q)
				ST_DISP: begin
					if (mode_q != MODE_PURSUIT && mode_q != MODE_WALL)
						mode_q <= (d2_q > WakeDist2) ? MODE_PURSUIT : MODE_IDLE;
				end
				ST_PFIN: begin
					if (d2_q < tol2_q) begin
						held_lin_q <= '0;
						held_ang_q <= '0;
						mode_q     <= MODE_IDLE;
					end else if (rf_q != '0 && {5'd0, rf_q} < trig_q) begin
						held_lin_q <= '0;
						held_ang_q <= '0;
						mode_q     <= MODE_WALL;
					end else begin
						if (d2_q < NearGoal2)
							held_lin_q <= {1'b0, lmin_q};
						else if (mag > Q12Pi16)
							held_lin_q <= '0;
						else
							held_lin_q <= {1'b0, lmax_q};
						held_ang_q <= (mag > Q12Pi16) ? ang_q : sat16(sonar_ang);
					end
				end
				ST_W4: begin
					if (rf_q != '0) begin
						if (rf_q < BackoffRange) begin
							held_ang_q <= '0;
							held_lin_q <= -$signed({2'd0, lmax_q[14:1]});
						end else begin
							held_ang_q <= wang_q;
							held_lin_q <= wlin_q;
						end
					end else if (rr_q != '0)
						held_lin_q <= sat16((prod_q + 36'sd2048) >>> 12);
					else
						held_lin_q <= {1'b0, lmax_q};
					if (rf_q == '0 && rl_q == '0 && rr_q == '0)
						mode_q <= MODE_PURSUIT;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_valid_q <= 1'b0;
		else if (state_q == ST_DONE && out_free)
			m_valid_q <= 1'b1;
		else if (m_tready)
			m_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			out_lin_q  <= held_lin_q;
			out_ang_q  <= held_ang_q;
			out_mode_q <= mode_q;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {6'd0, out_mode_q, out_ang_q, out_lin_q};

`ifndef NO_ASSERTIONS
	a_cord_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		cord_done |-> state_q == ST_CORD) else $error("cordic done outside wait");
	a_accept_seq: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == ST_SQX) else $error("accepted item did not start");
	a_result_out: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && out_free) |=> m_tvalid) else $error("result lost");
	a_mode_legal: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q != 2'd3) else $error("reserved mode code");
`endif

endmodule

// ===== dv/tb_bug0_navigation_controller.sv =====
module tb_bug0_navigation_controller;
	import bug0_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [79:0] s_tdata;   // pos_x, pos_y, heading, range_front, range_left, range_right
	logic        m_tvalid;
	logic        m_tready;
	logic [39:0] m_tdata;   // lin_cmd, ang_cmd, nav_mode
	logic        cfg_we;
	logic [2:0]  cfg_addr;
	logic [15:0] cfg_wdata;

	typedef struct packed {
		logic [9:0]         rr;
		logic [9:0]         rl;
		logic [9:0]         rf;
		logic signed [14:0] hdg;
		logic signed [15:0] py;
		logic signed [15:0] px;
	} tick_t;

	typedef struct packed {
		logic [1:0]         mode;
		logic signed [15:0] ang;
		logic signed [15:0] lin;
	} cmd_t;

	typedef struct {
		tick_t tick;
		bit    has_cmd;
		cmd_t  cmd;
	} vec_t;

	bug0_navigation_controller u_top (.*);

	// predictor state
	longint    gx, gy, lmax, lmin, amax, amin, tol, trig;
	nav_mode_t cur_mode;
	longint    h_lin, h_ang;
	cmd_t      cmd_q[$];
	vec_t      dir_q[$];
	int        errors;
	int        send_idle, recv_idle;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#40000000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	function automatic longint shr_floor(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint clamp16(longint v);
		if (v > 32767) return 32767;
		if (v < -32768) return -32768;
		return v;
	endfunction

	function automatic longint bearing(longint dx, longint dy);
		longint x, y, z, xo;
		longint tbl[16] = '{51472, 30385, 16055, 8150, 4091, 2047, 1024, 512,
			256, 128, 64, 32, 16, 8, 4, 2};
		x = dx * 256;
		y = dy * 256;
		z = 0;
		if (dx == 0 && dy == 0) return 0;
		if (x < 0) begin
			z = (y >= 0) ? 205887 : -205887;
			x = -x;
			y = -y;
		end
		for (int i = 0; i < 16; i++) begin
			xo = x;
			if (y >= 0) begin
				x = x + shr_floor(y, i);
				y = y - shr_floor(xo, i);
				z += tbl[i];
			end else begin
				x = x - shr_floor(y, i);
				y = y + shr_floor(xo, i);
				z -= tbl[i];
			end
		end
		return shr_floor(z + 8, 4);
	endfunction

	function automatic void cfg_model(reg_idx_t idx, logic [15:0] v);
		case (idx)
			REG_GOAL_X:    gx = longint'($signed(v));
			REG_GOAL_Y:    gy = longint'($signed(v));
			REG_LIN_MAX:   lmax = v[14:0];
			REG_LIN_MIN:   lmin = v[14:0];
			REG_ANG_MAX:   amax = v[14:0];
			REG_ANG_MIN:   amin = v[14:0];
			REG_GOAL_TOL:  tol = v[14:0];
			REG_OBST_TRIG: trig = v[14:0];
		endcase
	endfunction

	function automatic cmd_t nav_step(tick_t t);
		longint dx, dy, d2, err, mag, rate, lin, ang, rf, rl, rr;
		cmd_t c;
		rf = t.rf;
		rl = t.rl;
		rr = t.rr;
		dx = gx - longint'(t.px);
		dy = gy - longint'(t.py);
		d2 = dx * dx + dy * dy;
		if (cur_mode == MODE_PURSUIT) begin
			err = bearing(dx, dy) - longint'(t.hdg);
			while (err > 12868) err -= 25736;
			while (err <= -12868) err += 25736;
			mag = err < 0 ? -err : err;
			rate = (mag * 819 + 2048) >>> 12;
			if (rate > amax) rate = amax;
			if (rate < amin) rate = amin;
			ang = err < 0 ? -rate : rate;
			if (mag > 804) lin = 0;
			else begin
				lin = lmax;
				ang = shr_floor((rr - rl) * amax + 512, 10);
			end
			if (d2 < 512 * 512) lin = lmin;
			h_lin = clamp16(lin);
			h_ang = clamp16(ang);
			if (d2 < tol * tol) begin
				h_lin = 0;
				h_ang = 0;
				cur_mode = MODE_IDLE;
			end else if (rf > 0 && rf < trig) begin
				h_lin = 0;
				h_ang = 0;
				cur_mode = MODE_WALL;
			end
		end else if (cur_mode == MODE_WALL) begin
			if (rf != 0) begin
				if (rf < 205) begin
					h_ang = 0;
					h_lin = clamp16(-(lmax >>> 1));
				end else begin
					h_ang = clamp16(shr_floor(amax * (512 - rf) + 256, 9));
					h_lin = clamp16(shr_floor((rf - 102) * lmax + 512, 10));
				end
			end else if (rr > 0) h_lin = clamp16((lmax * 3277 + 2048) >>> 12);
			else h_lin = clamp16(lmax);
			if (rf == 0 && rl == 0 && rr == 0) cur_mode = MODE_PURSUIT;
		end else begin
			cur_mode = MODE_IDLE;
			if (d2 > 102 * 102) cur_mode = MODE_PURSUIT;
		end
		c.lin = h_lin[15:0];
		c.ang = h_ang[15:0];
		c.mode = cur_mode;
		return c;
	endfunction

	function automatic void add_row(tick_t t, bit has_cmd, cmd_t c);
		vec_t v;
		v.tick = t;
		v.has_cmd = has_cmd;
		v.cmd = c;
		dir_q.insert(dir_q.size(), v);
	endfunction

	task automatic write_reg(reg_idx_t idx, logic [15:0] v);
		cfg_we    <= 1'b1;
		cfg_addr  <= idx;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we    <= 1'b0;
		cfg_model(idx, v);
		@(posedge clk);
	endtask

	// drop valid and hold until every expected result has come
	task automatic wait_empty;
		s_tvalid <= 1'b0;
		while (cmd_q.size() != 0) @(posedge clk);
	endtask

	task automatic drain;
		wait_empty();
		repeat (40) @(posedge clk);
	endtask

	task automatic send_tick(tick_t t, bit has_cmd, cmd_t want);
		cmd_t c;
		while (send_idle > 0 && $urandom_range(99) < send_idle) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		c = nav_step(t);
		if (has_cmd && c !== want) begin
			$display("%0t directed tick: table %h, predictor %h", $time, want, c);
			errors++;
		end
		cmd_q.insert(cmd_q.size(), c);
		s_tvalid <= 1'b1;
		s_tdata  <= {3'b0, t};
		do @(posedge clk); while (!s_tready);
	endtask

	function automatic tick_t rand_tick(int near);
		tick_t t;
		t.px  = near ? 16'(gx + $signed($urandom_range(1400)) - 700) : 16'($urandom);
		t.py  = near ? 16'(gy + $signed($urandom_range(1400)) - 700) : 16'($urandom);
		t.hdg = ($urandom_range(9) == 0) ? 15'($urandom)
			: 15'($signed($urandom_range(25736)) - 12868);
		case ($urandom_range(5))
			0: begin t.rf = '0; t.rl = '0; t.rr = '0; end
			1: begin
				t.rf = '0;
				t.rl = 10'($urandom);
				t.rr = ($urandom_range(1) != 0) ? 10'd0 : 10'($urandom);
			end
			2: begin
				t.rf = 10'($urandom_range(1, 260));
				t.rl = 10'($urandom);
				t.rr = 10'($urandom);
			end
			default: begin
				t.rf = 10'($urandom);
				t.rl = 10'($urandom);
				t.rr = 10'($urandom);
			end
		endcase
		if (t.rf != 0 && $urandom_range(3) == 0) t.rf = 10'($urandom_range(1, 300));
		return t;
	endfunction

	// checker
	always @(posedge clk) begin
		cmd_t got, want;
		if (m_tvalid && m_tready) begin
			got = m_tdata[33:0];
			if (cmd_q.size() == 0) begin
				$display("%0t unexpected transaction: actual %h", $time, got);
				errors++;
			end else begin
				want = cmd_q.pop_front();
				if (got.lin !== want.lin)
					$display("%0t lin_cmd: expected %0d, actual %0d", $time, want.lin, got.lin);
				if (got.ang !== want.ang)
					$display("%0t ang_cmd: expected %0d, actual %0d", $time, want.ang, got.ang);
				if (got.mode !== want.mode)
					$display("%0t nav_mode: expected %0d, actual %0d", $time, want.mode, got.mode);
				if (got !== want) errors++;
			end
		end
	end

	// receiver stall
	initial begin
		m_tready = 1'b0;
		forever begin
			@(posedge clk);
			m_tready <= !(recv_idle > 0 && $urandom_range(99) < recv_idle);
		end
	end

	initial begin
		cmd_t  z;
		errors = 0;
		send_idle = 21;
		recv_idle = 57;
		s_tvalid = 1'b0;
		s_tdata = '0;
		cfg_we = 1'b0;
		cfg_addr = '0;
		cfg_wdata = '0;
		gx = 0; gy = 0; lmax = 1638; lmin = 819; amax = 2458; amin = 1638;
		tol = 102; trig = 512;
		cur_mode = MODE_IDLE;
		h_lin = 0;
		h_ang = 0;
		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// at goal, idle stays idle with zero command
		z = '0;
		add_row('{rr: 0, rl: 0, rf: 0, hdg: 0, py: 0, px: 0}, 1, z);
		// far away: wake into pursuit, command held
		z.mode = MODE_PURSUIT;
		add_row('{rr: 0, rl: 0, rf: 0, hdg: 0, py: 0, px: -16'sd2048}, 1, z);
		// on heading, sonar steering extremes
		add_row('{rr: 1023, rl: 0, rf: 0, hdg: 0, py: 0, px: -16'sd2048}, 0, z);
		add_row('{rr: 0, rl: 1023, rf: 0, hdg: 0, py: 0, px: -16'sd2048}, 0, z);
		// off heading, heading extremes and out of range heading
		add_row('{rr: 5, rl: 9, rf: 0, hdg: 15'sd12868, py: 0, px: -16'sd2048}, 0, z);
		add_row('{rr: 0, rl: 0, rf: 0, hdg: -15'sd12868, py: 16'sd700, px: 16'sd3}, 0, z);
		add_row('{rr: 0, rl: 0, rf: 0, hdg: 15'h3fff, py: 16'h8000, px: 16'h7fff}, 0, z);
		add_row('{rr: 0, rl: 0, rf: 0, hdg: 15'h4000, py: 16'h7fff, px: 16'h8000}, 0, z);
		// near goal approach
		add_row('{rr: 0, rl: 0, rf: 0, hdg: 0, py: 16'sd200, px: -16'sd300}, 0, z);
		// obstacle ahead: enter wall following, zero command
		z.mode = MODE_WALL;
		add_row('{rr: 0, rl: 0, rf: 100, hdg: 0, py: 0, px: -16'sd2048}, 1, z);
		// very close front: back off
		z.lin = -16'sd819;
		add_row('{rr: 0, rl: 0, rf: 100, hdg: 0, py: 0, px: -16'sd2048}, 1, z);
		add_row('{rr: 0, rl: 0, rf: 1023, hdg: 0, py: 0, px: -16'sd2048}, 0, z);
		add_row('{rr: 0, rl: 0, rf: 205, hdg: 0, py: 0, px: -16'sd2048}, 0, z);
		add_row('{rr: 7, rl: 0, rf: 0, hdg: 0, py: 0, px: -16'sd2048}, 0, z);
		add_row('{rr: 0, rl: 7, rf: 0, hdg: 0, py: 0, px: -16'sd2048}, 0, z);
		// all clear: back to pursuit
		add_row('{rr: 0, rl: 0, rf: 0, hdg: 0, py: 0, px: -16'sd2048}, 0, z);
		// arrival at goal: zero command, idle
		z = '0;
		add_row('{rr: 0, rl: 0, rf: 0, hdg: 0, py: 0, px: 16'sd10}, 1, z);
		foreach (dir_q[i]) send_tick(dir_q[i].tick, dir_q[i].has_cmd, dir_q[i].cmd);
		drain();

		// register extremes: goal at corner, angular limits crossed over
		write_reg(REG_GOAL_X, 16'h7fff);
		write_reg(REG_GOAL_Y, 16'h8000);
		write_reg(REG_LIN_MAX, 16'h7fff);
		write_reg(REG_LIN_MIN, 16'h0000);
		write_reg(REG_ANG_MAX, 16'h0000);
		write_reg(REG_ANG_MIN, 16'h7fff);
		write_reg(REG_GOAL_TOL, 16'h7fff);
		write_reg(REG_OBST_TRIG, 16'h7fff);
		z = '0;
		for (int i = 0; i < 6; i++) send_tick(rand_tick(i & 1), 0, z);
		drain();

		for (int ph = 0; ph < 3; ph++) begin
			case (ph)
				0: begin send_idle = 21; recv_idle = 57; end
				1: begin send_idle = 57; recv_idle = 21; end
				default: begin send_idle = 0; recv_idle = 0; end
			endcase
			write_reg(REG_GOAL_X, 16'($urandom));
			write_reg(REG_GOAL_Y, 16'($urandom));
			write_reg(REG_LIN_MAX, ph == 2 ? 16'h7fff : 16'($urandom_range(4000)));
			write_reg(REG_LIN_MIN, ph == 1 ? 16'h7fff : 16'($urandom_range(2000)));
			write_reg(REG_ANG_MAX, ph == 2 ? 16'h7fff : 16'($urandom_range(4000)));
			write_reg(REG_ANG_MIN, ph == 1 ? 16'h0000 : 16'($urandom_range(3000)));
			write_reg(REG_GOAL_TOL, 16'($urandom_range(300)));
			write_reg(REG_OBST_TRIG, ph == 0 ? 16'h0000 : 16'($urandom_range(1023)));
			for (int i = 0; i < 145; i++) begin
				// mostly near the goal so pursuit, arrival and walls all occur
				send_tick(rand_tick($urandom_range(4) != 0), 0, z);
				if (i == 70) wait_empty();
			end
			drain();
		end

		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
